@@ rtl/core/dsfc_pkg.sv @@
// Shared types, constants and CRC helpers for the stuffed frame encoder.
package dsfc_pkg;

  // Framing and CRC constants.
  localparam logic [7:0]  EscByte   = 8'h90;
  localparam logic [7:0]  StartByte = 8'h02;
  localparam logic [15:0] CrcPoly   = 16'h1021;

  // Depth of the command queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // What kind of work a queued command asks for.
  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_DATA,
    KIND_ERR
  } dsfc_kind_e;

  // Output sequencer steps of the back part.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ESC,
    ST_STX,
    ST_B0,
    ST_B0DUP,
    ST_B1,
    ST_B1DUP,
    ST_CRCLO,
    ST_CRCHI,
    ST_ERR
  } dsfc_step_e;

  // One classified item as passed from front to back.
  typedef struct packed {
    dsfc_kind_e  kind;
    logic [7:0]  b0;     // opcode or data byte
    logic [7:0]  b1;     // word count byte on headers
    logic        close;  // the frame closes with this item
    logic [15:0] crc;    // running CRC before the closing zero word
  } dsfc_cmd_t;

  // Feeds one byte, MSB first, into the CRC.
  function automatic logic [15:0] dsfc_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        carry;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      carry = c[15];
      c = {c[14:0], b[i]};
      if (carry) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  // Feeds one 16-bit word, MSB first, into the CRC.
  function automatic logic [15:0] dsfc_crc_word(input logic [15:0] crc, input logic [15:0] w);
    return dsfc_crc_byte(dsfc_crc_byte(crc, w[15:8]), w[7:0]);
  endfunction

endpackage

@@ rtl/core/dsfc_front.sv @@
// Front part: accepts items, tracks the open frame and the running CRC.
module dsfc_front import dsfc_pkg::*; #(
  parameter int MAX_WORDS = 127
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_type_i,
  input  logic [7:0] opcode_i,
  input  logic [6:0] word_count_i,
  input  logic [7:0] data_byte_i,
  output dsfc_cmd_t  cmd_o
);

  localparam logic [6:0] MaxCnt = 7'(MAX_WORDS);

  logic        frame_open_q, frame_open_d;
  logic        phase_q, phase_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] crc_q, crc_d;

  logic [6:0]  cnt_sat;
  logic [15:0] crc_hdr;
  logic [15:0] crc_data;
  logic        data_err;
  logic        data_close;

  // Header classification: saturate the count and seed the CRC.
  assign cnt_sat    = (word_count_i > MaxCnt) ? MaxCnt : word_count_i;
  assign crc_hdr    = dsfc_crc_word(16'h0000, {1'b0, cnt_sat, opcode_i});
  assign data_err   = !frame_open_q || (bytes_left_q == 8'd0);
  assign data_close = (bytes_left_q == 8'd1);
  assign crc_data   = phase_q ? dsfc_crc_word(crc_q, {data_byte_i, low_q}) : crc_q;

  // Build the command and the next frame state.
  always_comb begin
    frame_open_d = frame_open_q;
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    low_d        = low_q;
    crc_d        = crc_q;
    cmd_o        = '{kind: KIND_ERR, b0: 8'h00, b1: 8'h00, close: 1'b0, crc: crc_q};
    if (!req_type_i) begin
      cmd_o        = '{kind: KIND_HDR, b0: opcode_i, b1: {1'b0, cnt_sat},
                       close: (cnt_sat == 7'd0), crc: crc_hdr};
      crc_d        = crc_hdr;
      low_d        = 8'h00;
      phase_d      = 1'b0;
      bytes_left_d = (cnt_sat == 7'd0) ? 8'd0 : {cnt_sat, 1'b0};
      frame_open_d = (cnt_sat != 7'd0);
    end else if (!data_err) begin
      cmd_o   = '{kind: KIND_DATA, b0: data_byte_i, b1: 8'h00,
                  close: data_close, crc: crc_data};
      crc_d   = crc_data;
      phase_d = !phase_q;
      if (!phase_q) low_d = data_byte_i;
      bytes_left_d = bytes_left_q - 8'd1;
      if (data_close) begin
        frame_open_d = 1'b0;
        phase_d      = 1'b0;
      end
    end
  end

  // Frame control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      phase_q      <= 1'b0;
      bytes_left_q <= 8'd0;
    end else if (accept_i) begin
      frame_open_q <= frame_open_d;
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // CRC and held low byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
      low_q <= 8'h00;
    end else if (accept_i) begin
      crc_q <= crc_d;
      low_q <= low_d;
    end
  end

endmodule

@@ rtl/core/dsfc_queue.sv @@
// Short command queue between the front and back parts.
module dsfc_queue import dsfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dsfc_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output dsfc_cmd_t pop_cmd_o,
  output logic      empty_o
);

  dsfc_cmd_t              slots_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]       cnt_q;
  logic                   do_push, do_pop;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = slots_q[rd_ptr_q];

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_cmd_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/core/dsfc_back.sv @@
// Back part: expands queued commands into stuffed output words.
module dsfc_back import dsfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dsfc_cmd_t  q_cmd_i,
  input  logic       q_empty_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       last_o,
  output logic       error_o
);

  dsfc_step_e step_q, step_d;
  dsfc_step_e step_nxt;
  dsfc_step_e step_init;
  dsfc_cmd_t  cur_q;
  dsfc_cmd_t  cmd_fold;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       frame_end_q, last_q, error_q;
  logic       emit, done, take;
  logic [7:0] byte_now;
  logic       end_now, err_now;

  // The output register frees up when it is empty or being taken.
  assign emit    = (step_q != ST_IDLE) && (!out_valid_q || pop_i);
  assign take    = (step_q == ST_IDLE) || (emit && done);
  assign q_pop_o = take && !q_empty_i;

  // First step of a fresh command.
  always_comb begin
    case (q_cmd_i.kind)
      KIND_HDR:  step_init = ST_ESC;
      KIND_DATA: step_init = ST_B0;
      default:   step_init = ST_ERR;
    endcase
  end

  // Step sequencing and the word shown at the current step.
  always_comb begin
    step_nxt = ST_IDLE;
    done     = 1'b0;
    byte_now = 8'h00;
    end_now  = 1'b0;
    err_now  = 1'b0;
    case (step_q)
      ST_ESC: begin
        byte_now = EscByte;
        step_nxt = ST_STX;
      end
      ST_STX: begin
        byte_now = StartByte;
        step_nxt = ST_B0;
      end
      ST_B0, ST_B0DUP: begin
        byte_now = cur_q.b0;
        if (step_q == ST_B0 && cur_q.b0 == EscByte) step_nxt = ST_B0DUP;
        else if (cur_q.kind == KIND_HDR)           step_nxt = ST_B1;
        else if (cur_q.close)                      step_nxt = ST_CRCLO;
        else                                       done     = 1'b1;
      end
      ST_B1, ST_B1DUP: begin
        byte_now = cur_q.b1;
        if (step_q == ST_B1 && cur_q.b1 == EscByte) step_nxt = ST_B1DUP;
        else if (cur_q.close)                      step_nxt = ST_CRCLO;
        else                                       done     = 1'b1;
      end
      ST_CRCLO: begin
        byte_now = cur_q.crc[7:0];
        step_nxt = ST_CRCHI;
      end
      ST_CRCHI: begin
        byte_now = cur_q.crc[15:8];
        end_now  = 1'b1;
        done     = 1'b1;
      end
      ST_ERR: begin
        err_now = 1'b1;
        done    = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // Next step: load a new command or move on when a word goes out.
  always_comb begin
    step_d = step_q;
    if (take)      step_d = q_empty_i ? ST_IDLE : step_init;
    else if (emit) step_d = step_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= ST_IDLE;
    else         step_q <= step_d;
  end

  // The closing zero word is folded into the CRC of the incoming command.
  always_comb begin
    cmd_fold     = q_cmd_i;
    cmd_fold.crc = dsfc_crc_word(q_cmd_i.crc, 16'h0000);
  end

  // Current command.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= cmd_fold;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (emit)          out_valid_q <= 1'b1;
    else if (pop_i)         out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= byte_now;
      frame_end_q <= end_now;
      last_q      <= done;
      error_q     <= err_now;
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

endmodule

@@ rtl/core/dle_stuffed_frame_crc16_encoder_top.sv @@
// Top level of the DLE/STX frame encoder with CRC-16.
//
// Items enter through a queue-like port: an item is taken on a clock edge with
// push high and full low. A header item (req_type_i = 0) emits 0x90 0x02,
// the opcode and the word count, each doubled if it equals 0x90; a data item
// emits its byte, doubled if 0x90. After 2*count data bytes the CRC-16 follows,
// low byte first, with frame_end_o set on its high byte. A data byte with no
// open frame gives one word with error_o set.
// Results leave through a second queue-like port: the oldest word is shown
// while empty is low and is taken on an edge with pop high.
// An accepted item passes the command queue, the back part's step register and
// the output register. The back part sends one word per cycle while the
// receiver pops; an item makes one to seven words. A short command queue lets
// the front accept a new item every cycle until it fills. When the receiver
// stalls, the output word holds and the queue fills, after which full rises.
// Reset clears the frame state, the queue pointers and the output valid flag; no frame is
// open afterwards.
module dle_stuffed_frame_crc16_encoder_top import dsfc_pkg::*; #(
  parameter int MAX_WORDS = 127
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       req_type_i,
  input  logic [7:0] opcode_i,
  input  logic [6:0] word_count_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       last_o,
  output logic       error_o
);

  dsfc_cmd_t front_cmd;
  dsfc_cmd_t q_cmd;
  logic      q_empty;
  logic      q_pop;
  logic      accept;

  assign accept = push && !full;

  // Front: classification and frame state.
  dsfc_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .opcode_i     (opcode_i),
    .word_count_i (word_count_i),
    .data_byte_i  (data_byte_i),
    .cmd_o        (front_cmd)
  );

  // Command queue.
  dsfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .full_o     (full),
    .pop_i      (q_pop),
    .pop_cmd_o  (q_cmd),
    .empty_o    (q_empty)
  );

  // Back: word expansion and output register.
  dsfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_cmd_i     (q_cmd),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

`ifndef SYNTHESIS
  // The closing CRC byte always ends the item that caused it.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> last_o)
    else $error("frame end without last");

  // An error word stands alone and carries a zero byte.
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (last_o && !frame_end_o && out_byte_o == 8'h00))
    else $error("malformed error word");

  // The back part only draws from a queue that holds a command.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue drawn while empty");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the DLE/STX frame encoder with CRC-16.
module tb_top import dsfc_pkg::*; ();

  // Item kinds on req_type_i.
  localparam logic ReqHdr  = 1'b0;
  localparam logic ReqData = 1'b1;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandItems   = 160;
  localparam int unsigned MaxPrinted  = 30;

  // One output word as seen on the result ports.
  typedef struct packed {
    logic [7:0] val;
    logic       frame_end;
    logic       last;
    logic       err;
  } enc_word_t;

  // One row of the directed stimulus; typed rows carry their single word.
  typedef struct packed {
    logic       req;
    logic [7:0] op;
    logic [6:0] cnt;
    logic [7:0] dat;
    logic       typed;
    enc_word_t  want;
  } stim_row_t;

  localparam enc_word_t ErrWord = {8'h00, 1'b0, 1'b1, 1'b1};

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       req_type_i;
  logic [7:0] opcode_i;
  logic [6:0] word_count_i;
  logic [7:0] data_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       frame_end_o;
  logic       last_o;
  logic       error_o;

  dle_stuffed_frame_crc16_encoder_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .opcode_i     (opcode_i),
    .word_count_i (word_count_i),
    .data_byte_i  (data_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .last_o       (last_o),
    .error_o      (error_o)
  );

  // Clock with a period of 10 time units.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Frame state of the predictor.
  logic [15:0] crc_acc;
  logic [7:0]  bytes_todo;
  logic [7:0]  low_hold;
  logic        hi_phase;
  logic        in_frame;

  enc_word_t   item_words[$];
  enc_word_t   expected_words[$];
  stim_row_t   dir_rows[$];

  int unsigned n_mismatch;
  int unsigned n_items;
  int unsigned n_words;
  int unsigned n_frames;
  int unsigned n_err_words;
  int unsigned cycles;
  int unsigned rx_hold;
  bit          calm;

  // Counts one mismatch and reports each of the first MaxPrinted on a single line.
  task automatic report_mismatch(input string what, input int got, input int want);
    n_mismatch++;
    if (n_mismatch <= MaxPrinted)
      $display("mismatch at word %0d: %s got 0x%0h want 0x%0h", n_words, what, got, want);
  endtask

  // Shifts one 16-bit word, MSB first, into the CRC register.
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [15:0] w);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 15; i >= 0; i--) begin
      fb = r[15];
      r  = {r[14:0], w[i]};
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function automatic void emit(input logic [7:0] v, input logic fe);
    enc_word_t w;
    w = {v, fe, 1'b0, 1'b0};
    item_words.push_back(w);
  endfunction

  // Escape bytes go out twice.
  function automatic void emit_stuffed(input logic [7:0] v);
    emit(v, 1'b0);
    if (v == EscByte) emit(v, 1'b0);
  endfunction

  // Folds in the trailing zero word and appends the CRC, low byte first.
  function automatic void close_frame();
    crc_acc = crc_feed(crc_acc, 16'h0000);
    emit(crc_acc[7:0], 1'b0);
    emit(crc_acc[15:8], 1'b1);
    in_frame   = 1'b0;
    bytes_todo = 8'd0;
    hi_phase   = 1'b0;
  endfunction

  // Works out the words that one accepted item produces.
  function automatic void predict_item(input logic req, input logic [7:0] op,
                                       input logic [6:0] cnt, input logic [7:0] dat);
    enc_word_t w;
    item_words.delete();
    if (req == ReqHdr) begin
      emit(EscByte, 1'b0);
      emit(StartByte, 1'b0);
      emit_stuffed(op);
      emit_stuffed({1'b0, cnt});
      crc_acc    = crc_feed(16'h0000, {1'b0, cnt, op});
      low_hold   = 8'h00;
      hi_phase   = 1'b0;
      bytes_todo = {cnt, 1'b0};
      in_frame   = 1'b1;
      if (cnt == 7'd0) close_frame();
    end else if (!in_frame || bytes_todo == 8'd0) begin
      w = {8'h00, 1'b0, 1'b0, 1'b1};
      item_words.push_back(w);
    end else begin
      emit_stuffed(dat);
      if (!hi_phase) begin
        low_hold = dat;
        hi_phase = 1'b1;
      end else begin
        crc_acc  = crc_feed(crc_acc, {dat, low_hold});
        hi_phase = 1'b0;
      end
      bytes_todo = bytes_todo - 8'd1;
      if (bytes_todo == 8'd0) close_frame();
    end
    w = item_words[item_words.size() - 1];
    w.last = 1'b1;
    item_words[item_words.size() - 1] = w;
  endfunction

  // Idle length: mostly none, sometimes short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic stim_row_t mk(input logic req, input logic [7:0] op, input logic [6:0] cnt,
                                   input logic [7:0] dat, input logic typed);
    stim_row_t s;
    s = {req, op, cnt, dat, typed, ErrWord};
    return s;
  endfunction

  // Presents one item, waits until it is taken and records what it must produce.
  task automatic send_item(input logic req, input logic [7:0] op, input logic [6:0] cnt,
                           input logic [7:0] dat, input logic typed, input enc_word_t want);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    req_type_i   <= req;
    opcode_i     <= op;
    word_count_i <= cnt;
    data_byte_i  <= dat;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end
    predict_item(req, op, cnt, dat);
    if (typed) expected_words.push_back(want);
    else foreach (item_words[i]) expected_words.push_back(item_words[i]);
    n_items++;
  endtask

  // Random byte with a strong bias towards the escape value.
  function automatic logic [7:0] rand_byte(input int unsigned esc_pct);
    if ($urandom_range(0, 99) < esc_pct) return EscByte;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: pops with random stalls of varying length.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop     <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      pop     <= 1'b0;
    end else if ($urandom_range(0, 3) == 0 && pick_gap() > 0) begin
      rx_hold <= pick_gap();
      pop     <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Compares each popped word with the oldest expectation.
  always @(negedge clk_i) begin
    enc_word_t exp_w;
    if (rst_ni && pop && !empty) begin
      if (frame_end_o) n_frames++;
      if (error_o) n_err_words++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, out_byte", out_byte_o, 0);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_byte_o !== exp_w.val) report_mismatch("out_byte", out_byte_o, exp_w.val);
        if (frame_end_o !== exp_w.frame_end)
          report_mismatch("frame_end", frame_end_o, exp_w.frame_end);
        if (last_o !== exp_w.last) report_mismatch("last", last_o, exp_w.last);
        if (error_o !== exp_w.err) report_mismatch("error", error_o, exp_w.err);
      end
      n_words++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, expected_words.size());
      $display("dle_stuffed_frame_crc16_encoder_top regression: fail");
      $finish;
    end
  end

  // Stimulus: directed table, then random frames with noise.
  initial begin
    stim_row_t   row;
    int unsigned cnt_r;
    int unsigned n_data;
    logic [6:0]  cnt;

    rst_ni       = 1'b0;
    push         = 1'b0;
    req_type_i   = ReqHdr;
    opcode_i     = 8'h00;
    word_count_i = 7'd0;
    data_byte_i  = 8'h00;
    crc_acc      = 16'h0000;
    bytes_todo   = 8'd0;
    low_hold     = 8'h00;
    hi_phase     = 1'b0;
    in_frame     = 1'b0;
    calm         = 1'b0;
    n_items      = 0;

    // Data with no open frame after reset, then an escaped opcode with zero words.
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h5A, 1'b1));
    dir_rows.push_back(mk(ReqHdr,  8'h90, 7'd0,   8'hFF, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'hFF, 7'h7F,  8'h00, 1'b1));
    // Largest word count, cut short by a new header.
    dir_rows.push_back(mk(ReqHdr,  8'h00, 7'd127, 8'h00, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'hFF, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h90, 1'b0));
    dir_rows.push_back(mk(ReqHdr,  8'hFF, 7'd1,   8'h00, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h90, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h00, 1'b0));
    // Abort between the two bytes of a word.
    dir_rows.push_back(mk(ReqHdr,  8'h3C, 7'd2,   8'h00, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h90, 1'b0));
    dir_rows.push_back(mk(ReqHdr,  8'hA5, 7'd2,   8'h00, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'hFF, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h90, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h01, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'h7E, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h00, 7'd0,   8'hFF, 1'b1));
    // Escape value everywhere in one frame.
    dir_rows.push_back(mk(ReqHdr,  8'h90, 7'd1,   8'h90, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h90, 7'd1,   8'h90, 1'b0));
    dir_rows.push_back(mk(ReqData, 8'h90, 7'd1,   8'h90, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.req, row.op, row.cnt, row.dat, row.typed, row.want);
    end

    // Mostly complete frames with random content; stray data and truncated frames mixed in.
    while (n_items < dir_rows.size() + RandItems) begin
      if ((n_items / 40) % 3 == 2) calm = 1'b1;
      else calm = 1'b0;
      if ($urandom_range(0, 99) < 8) begin
        send_item(ReqData, 8'($urandom), 7'($urandom), rand_byte(20), 1'b0, ErrWord);
      end else begin
        cnt_r = $urandom_range(0, 99);
        if (cnt_r < 70) cnt = 7'($urandom_range(0, 4));
        else if (cnt_r < 95) cnt = 7'($urandom_range(5, 12));
        else cnt = 7'($urandom_range(13, 40));
        send_item(ReqHdr, rand_byte(15), cnt, 8'($urandom), 1'b0, ErrWord);
        n_data = 2 * cnt;
        if ($urandom_range(0, 9) == 0) n_data = $urandom_range(0, 2 * cnt);
        repeat (n_data)
          send_item(ReqData, 8'($urandom), 7'($urandom), rand_byte(20), 1'b0, ErrWord);
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d items giving %0d words: %0d frames closed, %0d orphan data errors",
             n_items, n_words, n_frames, n_err_words);
    $display("%0d mismatches in %0d cycles", n_mismatch, cycles);
    if (n_mismatch == 0) begin
      $display("dle_stuffed_frame_crc16_encoder_top regression: pass");
    end else begin
      $display("dle_stuffed_frame_crc16_encoder_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dsfc_pkg.sv
rtl/core/dsfc_front.sv
rtl/core/dsfc_queue.sv
rtl/core/dsfc_back.sv
rtl/core/dle_stuffed_frame_crc16_encoder_top.sv
tb/tb_top.sv
